### hdl/assert_macros.svh
// Assertion helpers; each expects signals named clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define GAP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define GAP_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

// Check that a condition holds in the same cycle as a trigger.
`define GAP_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

`endif

### hdl/gap_pkg.sv
`default_nettype none
package gap_pkg;

  localparam int ALLELE_MAX_DEF      = 65535;
  localparam int MAX_FIELD_INDEX_DEF = 15;
  localparam int RESULT_W            = 17;
  localparam int CFG_W               = 4;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Samples shorter than this give both alleles missing.
  localparam logic [1:0] SHORT_LENGTH = 2'd3;

  // Status bits of missing_code.
  localparam logic [1:0] MISS_FIRST  = 2'b01;
  localparam logic [1:0] MISS_SECOND = 2'b10;
  localparam logic [1:0] MISS_BOTH   = 2'b11;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } gap_byte_t;

  typedef struct packed {
    logic valid;
    logic take;
  } gap_link_t;

endpackage
`default_nettype wire

### hdl/gap_in_reg.sv
`default_nettype none
module gap_in_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          char_byte,
  input  wire logic                last_byte,
  input  wire logic                take,
  output logic                     held_valid,
  output gap_pkg::gap_byte_t       held
);

  // Stall only while a held word waits for the parser.
  assign in_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      held.char_byte <= char_byte;
      held.last_byte <= last_byte;
    end
  end

endmodule
`default_nettype wire

### hdl/gap_parser.sv
`default_nettype none
`include "assert_macros.svh"
module gap_parser #(
  parameter int ALLELE_MAX      = gap_pkg::ALLELE_MAX_DEF,
  parameter int MAX_FIELD_INDEX = gap_pkg::MAX_FIELD_INDEX_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [gap_pkg::CFG_W-1:0]         field_index,
  input  wire gap_pkg::gap_byte_t                held,
  output gap_pkg::gap_link_t                     link,
  input  wire logic                              held_valid,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [gap_pkg::RESULT_W-1:0]    first_allele,
  output logic signed [gap_pkg::RESULT_W-1:0]    second_allele,
  output logic [1:0]                             missing_code
);

  localparam int RW = gap_pkg::RESULT_W;
  localparam int VW = $clog2(longint'(ALLELE_MAX) + 64'd1);
  localparam int AW = (VW > RW) ? VW : RW;
  localparam int PW = VW + 4;
  localparam int TW = $clog2(MAX_FIELD_INDEX + 3);
  localparam int CW = (TW > gap_pkg::CFG_W) ? TW : gap_pkg::CFG_W;

  typedef enum logic [2:0] {
    FORM_NONE,
    FORM_DOT,
    FORM_SIGN,
    FORM_DIGITS,
    FORM_OTHER
  } form_t;

  localparam logic [1:0] SLOT_NONE   = 2'd0;
  localparam logic [1:0] SLOT_FIRST  = 2'd1;
  localparam logic [1:0] SLOT_SECOND = 2'd2;
  localparam logic [1:0] SLOT_CLOSED = 2'd3;

  logic [1:0]          length_seen, length_seen_next;
  logic [TW-1:0]       token_index, token_index_next;
  logic                inside_token, inside_token_next;
  logic [1:0]          allele_slot, allele_slot_next;
  form_t               sub_token_form, sub_token_form_next;
  logic                negative_sign, negative_sign_next;
  logic                digits_ended, digits_ended_next;
  logic [VW-1:0]       value_accum, value_accum_next;
  logic [RW-1:0]       first_value, first_value_next;
  logic                first_missing, first_missing_next;

  logic [CW-1:0]       sel_index;
  logic [TW-1:0]       target;
  logic                take;
  logic                out_free;
  logic                is_colon, is_sep, is_digit;
  logic [3:0]          digit_val;
  logic [PW-1:0]       digit_sum;
  logic [VW-1:0]       accum_add;
  logic                restart;
  form_t               form_cur;
  logic                close_en, feed_en;
  logic [AW-1:0]       accum_ext;
  logic [RW-1:0]       value_now;
  logic                second_dot;
  logic                short_sample;
  logic [RW-1:0]       result_first, result_second;
  logic [1:0]          result_code;

  // Clamp the configured token position and turn it into a token count.
  assign sel_index = (CW'(field_index) > CW'(MAX_FIELD_INDEX)) ?
                     CW'(MAX_FIELD_INDEX) : CW'(field_index);
  assign target    = TW'(sel_index) + TW'(1);

  assign out_free  = !out_valid || !out_stall;
  assign take      = held_valid && (!held.last_byte || out_free);
  assign link.valid = held_valid;
  assign link.take  = take;

  assign is_colon  = (held.char_byte == gap_pkg::CH_COLON);
  assign is_sep    = (held.char_byte == gap_pkg::CH_SLASH) ||
                     (held.char_byte == gap_pkg::CH_BAR);
  assign is_digit  = (held.char_byte >= gap_pkg::CH_ZERO) &&
                     (held.char_byte <= gap_pkg::CH_NINE);
  assign digit_val = 4'(held.char_byte - gap_pkg::CH_ZERO);

  // Multiply by ten and saturate at the allele bound.
  assign digit_sum = PW'(value_accum) * PW'(10) + PW'(digit_val);
  assign accum_add = (digit_sum > PW'(ALLELE_MAX)) ? VW'(ALLELE_MAX) : digit_sum[VW-1:0];

  assign restart  = (allele_slot == SLOT_NONE) ||
                    ((allele_slot == SLOT_FIRST) && (sub_token_form == FORM_NONE));
  assign form_cur = restart ? FORM_NONE : sub_token_form;

  always_comb begin
    length_seen_next    = (length_seen == 2'd3) ? 2'd3 : length_seen + 2'd1;
    token_index_next    = token_index;
    inside_token_next   = inside_token;
    allele_slot_next    = allele_slot;
    sub_token_form_next = sub_token_form;
    negative_sign_next  = negative_sign;
    digits_ended_next   = digits_ended;
    value_accum_next    = value_accum;
    first_value_next    = first_value;
    first_missing_next  = first_missing;
    close_en            = 1'b0;
    feed_en             = 1'b0;

    // Token tracking.
    if (is_colon) begin
      close_en          = inside_token && (token_index == target);
      inside_token_next = 1'b0;
    end else begin
      if (!inside_token) begin
        inside_token_next = 1'b1;
        if (token_index < TW'(MAX_FIELD_INDEX + 2)) begin
          token_index_next = token_index + TW'(1);
        end
      end
      if (token_index_next == target) begin
        if (is_sep) begin
          close_en = 1'b1;
        end else begin
          feed_en = 1'b1;
        end
      end
    end
    if (held.last_byte && (token_index_next == target)) begin
      close_en = 1'b1;
    end

    // Allele character handling.
    if (feed_en && (allele_slot != SLOT_CLOSED)) begin
      if (restart) begin
        allele_slot_next    = allele_slot + 2'd1;
        sub_token_form_next = FORM_NONE;
        negative_sign_next  = 1'b0;
        digits_ended_next   = 1'b0;
        value_accum_next    = '0;
      end
      case (form_cur)
        FORM_NONE: begin
          if (held.char_byte == gap_pkg::CH_DOT) begin
            sub_token_form_next = FORM_DOT;
            digits_ended_next   = 1'b1;
          end else if ((held.char_byte == gap_pkg::CH_PLUS) ||
                       (held.char_byte == gap_pkg::CH_MINUS)) begin
            sub_token_form_next = FORM_SIGN;
            negative_sign_next  = (held.char_byte == gap_pkg::CH_MINUS);
          end else if (is_digit) begin
            sub_token_form_next = FORM_DIGITS;
            value_accum_next    = VW'(digit_val);
          end else begin
            sub_token_form_next = FORM_OTHER;
            digits_ended_next   = 1'b1;
          end
        end
        FORM_DOT: begin
          sub_token_form_next = FORM_OTHER;
        end
        FORM_SIGN: begin
          if (is_digit) begin
            sub_token_form_next = FORM_DIGITS;
            value_accum_next    = accum_add;
          end else begin
            sub_token_form_next = FORM_OTHER;
            digits_ended_next   = 1'b1;
          end
        end
        FORM_DIGITS: begin
          if (!digits_ended && is_digit) begin
            value_accum_next = accum_add;
          end else begin
            digits_ended_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // Signed value of the allele in progress, kept to the result width.
    accum_ext = AW'(value_accum_next);
    if (sub_token_form_next == FORM_DOT) begin
      value_now = '1;
    end else if (negative_sign_next) begin
      value_now = -accum_ext[RW-1:0];
    end else begin
      value_now = accum_ext[RW-1:0];
    end
    second_dot = (sub_token_form_next == FORM_DOT);

    // Close the allele in progress.
    if (close_en) begin
      if ((allele_slot_next == SLOT_FIRST) && (sub_token_form_next != FORM_NONE)) begin
        first_missing_next  = (sub_token_form_next == FORM_DOT);
        first_value_next    = value_now;
        sub_token_form_next = FORM_NONE;
      end else if (allele_slot_next == SLOT_SECOND) begin
        allele_slot_next = SLOT_CLOSED;
      end
    end

    // Result of the sample.
    short_sample = (length_seen_next != gap_pkg::SHORT_LENGTH) ||
                   (token_index_next < target);
    result_code  = '0;
    if (short_sample) begin
      result_first  = '1;
      result_second = '1;
      result_code   = gap_pkg::MISS_BOTH;
    end else begin
      if (allele_slot_next != SLOT_NONE) begin
        result_first = first_value_next;
        if (first_missing_next) begin
          result_code = result_code | gap_pkg::MISS_FIRST;
        end
      end else begin
        result_first = '1;
        result_code  = result_code | gap_pkg::MISS_FIRST;
      end
      if ((allele_slot_next == SLOT_SECOND) || (allele_slot_next == SLOT_CLOSED)) begin
        result_second = value_now;
        if (second_dot) begin
          result_code = result_code | gap_pkg::MISS_SECOND;
        end
      end else begin
        result_second = '1;
        result_code   = result_code | gap_pkg::MISS_SECOND;
      end
    end
  end

  // Advance the sample state; drop it all once the last byte is taken.
  always_ff @(posedge clk) begin
    if (rst || (take && held.last_byte)) begin
      length_seen    <= '0;
      token_index    <= '0;
      inside_token   <= 1'b0;
      allele_slot    <= SLOT_NONE;
      sub_token_form <= FORM_NONE;
      negative_sign  <= 1'b0;
      digits_ended   <= 1'b0;
      value_accum    <= '0;
      first_value    <= '0;
      first_missing  <= 1'b0;
    end else if (take) begin
      length_seen    <= length_seen_next;
      token_index    <= token_index_next;
      inside_token   <= inside_token_next;
      allele_slot    <= allele_slot_next;
      sub_token_form <= sub_token_form_next;
      negative_sign  <= negative_sign_next;
      digits_ended   <= digits_ended_next;
      value_accum    <= value_accum_next;
      first_value    <= first_value_next;
      first_missing  <= first_missing_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && held.last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && held.last_byte) begin
      first_allele  <= result_first;
      second_allele <= result_second;
      missing_code  <= result_code;
    end
  end

  `GAP_ASSERT_NEXT(a_clear_after_last, take && held.last_byte,
    (allele_slot == SLOT_NONE) && (token_index == '0) && (length_seen == 2'd0),
    "sample state not cleared after last byte")
  `GAP_ASSERT_ALWAYS(a_accum_bounded, PW'(value_accum) <= PW'(ALLELE_MAX),
    "allele accumulator above bound")
  `GAP_ASSERT_SAME(a_first_missing_value, out_valid && missing_code[0],
    first_allele == '1, "first allele flagged missing but not -1")
  `GAP_ASSERT_SAME(a_second_missing_value, out_valid && missing_code[1],
    second_allele == '1, "second allele flagged missing but not -1")
  `GAP_ASSERT_ALWAYS(a_token_bounded, token_index <= TW'(MAX_FIELD_INDEX + 2),
    "token count beyond saturation")

endmodule
`default_nettype wire

### hdl/genotype_allele_parser_core.sv
`default_nettype none
// Genotype allele parser: takes one sample string a byte per word on the input
// channel and, on the word that carries last_byte, returns one result word holding
// the two allele numbers (-1 when missing, magnitude saturated at ALLELE_MAX) and a
// two-bit missing code. Tokens are split at ':' and the token chosen by
// genotype_field_index (clamped to MAX_FIELD_INDEX) is split at '/' or '|'; empty
// tokens and sub-tokens are skipped, and a missing token or allele is reported as
// missing. Samples under three bytes give -1, -1 and code 3. Throughput is one byte
// per cycle while the input does not stall: the per-byte state update, including
// the multiply by ten of the allele accumulator, sits between the input register
// and the state and result registers, which a last byte passes in order. The
// input keeps taking non-final bytes while a result waits on a stalled output; a
// final byte waits until the result register is free. Write genotype_field_index
// only while no sample is in flight; the config port never pushes back.
module genotype_allele_parser_core #(
  parameter int ALLELE_MAX      = gap_pkg::ALLELE_MAX_DEF,
  parameter int MAX_FIELD_INDEX = gap_pkg::MAX_FIELD_INDEX_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Config write channel.
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [gap_pkg::CFG_W-1:0]          genotype_field_index,
  // Byte input channel.
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [7:0]                         char_byte,
  input  wire logic                               last_byte,
  // Result channel.
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [gap_pkg::RESULT_W-1:0]     first_allele,
  output logic signed [gap_pkg::RESULT_W-1:0]     second_allele,
  output logic [1:0]                              missing_code
);

  logic [gap_pkg::CFG_W-1:0] field_index;
  logic                      held_valid;
  gap_pkg::gap_byte_t        held;
  gap_pkg::gap_link_t        link;

  // Config register: always ready, takes the write data on the handshake.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index <= '0;
    end else if (cfg_valid && cfg_ready) begin
      field_index <= genotype_field_index;
    end
  end

  // Input register: hold one byte word for the parser.
  gap_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_byte  (char_byte),
    .last_byte  (last_byte),
    .take       (link.take),
    .held_valid (held_valid),
    .held       (held)
  );

  // Parser: per-byte state update and result register.
  gap_parser #(
    .ALLELE_MAX      (ALLELE_MAX),
    .MAX_FIELD_INDEX (MAX_FIELD_INDEX)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .field_index   (field_index),
    .held          (held),
    .link          (link),
    .held_valid    (held_valid),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .first_allele  (first_allele),
    .second_allele (second_allele),
    .missing_code  (missing_code)
  );

endmodule
`default_nettype wire

### tb/tb_genotype_allele_parser_core.sv
`timescale 1ns / 100ps

module tb_genotype_allele_parser_core;
  import gap_pkg::*;

  localparam int CYCLE_LIMIT       = 200000;
  localparam int PHASE_BYTES       = 120;
  localparam int LONG_HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES     = 4;

  // Sub-token classes tracked while an allele is being read.
  typedef enum logic [2:0] {
    SUB_NONE,
    SUB_DOT,
    SUB_SIGN,
    SUB_DIGITS,
    SUB_OTHER
  } sub_form_t;

  typedef struct {
    logic signed [RESULT_W-1:0] allele_a;
    logic signed [RESULT_W-1:0] allele_b;
    logic [1:0]                 miss;
  } allele_result_t;

  // Clock, reset and block-facing signals; every input starts at a known value.
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_W-1:0]           genotype_field_index = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 char_byte = 8'h41;
  logic                       last_byte = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [RESULT_W-1:0] first_allele;
  logic signed [RESULT_W-1:0] second_allele;
  logic [1:0]                 missing_code;

  // Bytes waiting to be offered, and allele results still owed by the block.
  gap_byte_t      sample_bytes[$];
  allele_result_t pending_alleles[$];
  logic [7:0]     sample_buf[$];

  // Traffic shaping, set per phase by the stimulus process.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_results = 1'b0;
  bit byte_taken = 1'b0;
  int bytes_queued = 0;
  int err_count = 0;
  int cycle_count = 0;

  // Shadow of the parser: the selected field and the per-sample state.
  logic [CFG_W-1:0]           field_sel = '0;
  logic [1:0]                 len_seen;
  logic [4:0]                 tok_idx;
  logic                       in_tok;
  logic [1:0]                 slot;
  sub_form_t                  form;
  logic                       neg;
  logic                       dig_end;
  logic [15:0]                accum;
  logic signed [RESULT_W-1:0] first_val;
  logic                       first_miss;

  genotype_allele_parser_core u_top (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .genotype_field_index (genotype_field_index),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .char_byte            (char_byte),
    .last_byte            (last_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .first_allele         (first_allele),
    .second_allele        (second_allele),
    .missing_code         (missing_code)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Allele predictor
  // ---------------------------------------------------------------------------

  // Drop all per-sample state; done at reset and after every result.
  function automatic void clear_sample();
    len_seen   = '0;
    tok_idx    = '0;
    in_tok     = 1'b0;
    slot       = '0;
    form       = SUB_NONE;
    neg        = 1'b0;
    dig_end    = 1'b0;
    accum      = '0;
    first_val  = '0;
    first_miss = 1'b0;
  endfunction

  // Value of the sub-token in progress: -1 for a lone dot, else signed magnitude.
  function automatic logic signed [RESULT_W-1:0] allele_now();
    logic signed [RESULT_W-1:0] mag;
    if (form == SUB_DOT) return -1;
    mag = {1'b0, accum};
    return neg ? -mag : mag;
  endfunction

  // Shift in one decimal digit, pinning the magnitude at the allele bound.
  function automatic void shift_digit(input logic [7:0] c);
    int unsigned v;
    v = 32'(accum) * 32'd10 + 32'(c - CH_ZERO);
    accum = (v > ALLELE_MAX_DEF) ? 16'(ALLELE_MAX_DEF) : 16'(v);
  endfunction

  // Close the sub-token in progress: latch the first allele, or seal the second.
  function automatic void close_allele();
    if (slot == 2'd1 && form != SUB_NONE) begin
      first_miss = (form == SUB_DOT);
      first_val  = allele_now();
      form       = SUB_NONE;
    end else if (slot == 2'd2) begin
      slot = 2'd3;
    end
  endfunction

  // Advance the allele reader by one non-separator byte of the genotype token.
  function automatic void read_allele_char(input logic [7:0] c);
    logic is_digit;
    is_digit = (c >= CH_ZERO && c <= CH_NINE);
    if (slot == 2'd3) return;
    if (slot == 2'd0 || (slot == 2'd1 && form == SUB_NONE)) begin
      slot    = slot + 2'd1;
      form    = SUB_NONE;
      neg     = 1'b0;
      dig_end = 1'b0;
      accum   = '0;
    end
    case (form)
      SUB_NONE: begin
        if (c == CH_DOT) begin
          form    = SUB_DOT;
          dig_end = 1'b1;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          form = SUB_SIGN;
          neg  = (c == CH_MINUS);
        end else if (is_digit) begin
          form  = SUB_DIGITS;
          accum = 16'(c - CH_ZERO);
        end else begin
          form    = SUB_OTHER;
          dig_end = 1'b1;
        end
      end
      SUB_DOT: form = SUB_OTHER;
      SUB_SIGN: begin
        if (is_digit) begin
          form = SUB_DIGITS;
          shift_digit(c);
        end else begin
          form    = SUB_OTHER;
          dig_end = 1'b1;
        end
      end
      SUB_DIGITS: begin
        if (!dig_end && is_digit) shift_digit(c);
        else dig_end = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Take one accepted byte; return 1 with the expected result on the final byte.
  function automatic bit take_byte(input logic [7:0] c, input logic lst,
                                   output allele_result_t r);
    logic [4:0] tgt;
    logic [1:0] code;
    tgt = (field_sel > MAX_FIELD_INDEX_DEF) ? 5'(MAX_FIELD_INDEX_DEF) + 5'd1
                                            : 5'(field_sel) + 5'd1;
    if (len_seen < SHORT_LENGTH) len_seen = len_seen + 2'd1;

    if (c == CH_COLON) begin
      if (in_tok && tok_idx == tgt) close_allele();
      in_tok = 1'b0;
    end else begin
      if (!in_tok) begin
        in_tok = 1'b1;
        if (tok_idx < MAX_FIELD_INDEX_DEF + 2) tok_idx = tok_idx + 5'd1;
      end
      if (tok_idx == tgt) begin
        if (c == CH_SLASH || c == CH_BAR) close_allele();
        else read_allele_char(c);
      end
    end

    if (!lst) return 1'b0;

    if (tok_idx == tgt) close_allele();

    if (len_seen < SHORT_LENGTH || tok_idx < tgt) begin
      r.allele_a = -1;
      r.allele_b = -1;
      r.miss     = MISS_BOTH;
    end else begin
      code = '0;
      if (slot >= 2'd1) begin
        r.allele_a = first_val;
        if (first_miss) code = code | MISS_FIRST;
      end else begin
        r.allele_a = -1;
        code = code | MISS_FIRST;
      end
      if (slot >= 2'd2) begin
        r.allele_b = allele_now();
        if (form == SUB_DOT) code = code | MISS_SECOND;
      end else begin
        r.allele_b = -1;
        code = code | MISS_SECOND;
      end
      r.miss = code;
    end
    clear_sample();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample text generation
  // ---------------------------------------------------------------------------

  // Printable filler that never splits a token.
  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h21, 8'h7E));
    if (c == CH_COLON) c = "A";
    return c;
  endfunction

  // Any nonzero byte, leaning toward the ones the parser reacts to.
  function automatic logic [7:0] noise_char();
    case ($urandom_range(7))
      0:       return CH_COLON;
      1:       return CH_SLASH;
      2:       return CH_BAR;
      3:       return CH_DOT;
      4:       return CH_MINUS;
      5:       return CH_ZERO + 8'($urandom_range(9));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Move the assembled sample to the driver queue, flagging its final byte.
  task automatic flush_sample();
    gap_byte_t w;
    foreach (sample_buf[i]) begin
      w.char_byte = sample_buf[i];
      w.last_byte = (i == sample_buf.size() - 1);
      sample_bytes.push_back(w);
    end
    bytes_queued += sample_buf.size();
    sample_buf.delete();
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) sample_buf.push_back(s[i]);
    flush_sample();
  endtask

  // One allele: a dot, a dot with junk, a bare sign, or a signed number,
  // sometimes long enough to saturate and sometimes trailed by junk.
  task automatic put_allele();
    int kind;
    int n;
    kind = $urandom_range(19);
    if (kind < 3) begin
      sample_buf.push_back(CH_DOT);
    end else if (kind == 3) begin
      sample_buf.push_back(CH_DOT);
      sample_buf.push_back($urandom_range(1) ? CH_ZERO + 8'($urandom_range(9))
                                             : filler_char());
    end else if (kind == 4) begin
      sample_buf.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
      if ($urandom_range(1)) sample_buf.push_back(filler_char());
    end else begin
      if ($urandom_range(3) == 0) sample_buf.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
      n = ($urandom_range(7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
      repeat (n) sample_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
      if (kind >= 18) sample_buf.push_back(filler_char());
      if (kind == 19) sample_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
  endtask

  // Genotype token: mostly two alleles, sometimes none, one, or extras;
  // separators now and then doubled or leading so empty sub-tokens show up.
  task automatic put_genotype();
    int r;
    int n;
    r = $urandom_range(15);
    n = (r == 0) ? 0 : (r == 1) ? 1 : (r < 14) ? 2 : $urandom_range(3, 4);
    if (n == 0 || $urandom_range(7) == 0) sample_buf.push_back($urandom_range(1) ? CH_SLASH : CH_BAR);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        sample_buf.push_back($urandom_range(1) ? CH_SLASH : CH_BAR);
        if ($urandom_range(7) == 0) sample_buf.push_back(CH_SLASH);
      end
      put_allele();
    end
  endtask

  // One random sample: mostly a well-formed record at the selected field,
  // with short samples, raw noise and wrong token counts mixed in.
  task automatic queue_sample();
    int r;
    int ntok;
    r = $urandom_range(19);
    if (r == 0) begin
      repeat ($urandom_range(1, 2)) sample_buf.push_back(noise_char());
    end else if (r <= 2) begin
      repeat ($urandom_range(1, 12)) sample_buf.push_back(noise_char());
    end else begin
      ntok = int'(field_sel) + 1;
      if ($urandom_range(9) == 0) ntok = $urandom_range(0, field_sel);
      else if ($urandom_range(9) == 0) ntok += $urandom_range(1, 3);
      if ($urandom_range(9) == 0) sample_buf.push_back(CH_COLON);
      for (int t = 0; t < ntok; t++) begin
        if (t > 0) begin
          sample_buf.push_back(CH_COLON);
          if ($urandom_range(9) == 0) sample_buf.push_back(CH_COLON);
        end
        if (t == field_sel) put_genotype();
        else repeat ($urandom_range(1, 3)) sample_buf.push_back(filler_char());
      end
      if ($urandom_range(9) == 0) sample_buf.push_back(CH_COLON);
    end
    if (sample_buf.size() == 0) sample_buf.push_back(filler_char());
    flush_sample();
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  // Hold until every queued byte went in and every owed result came out,
  // then let the block settle any trailing work.
  task automatic wait_drained();
    while (sample_bytes.size() != 0 || in_valid || pending_alleles.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the field-index register; the shadow copy follows at the accepting edge.
  task automatic set_field_index(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    genotype_field_index <= v;
    do @(posedge clk); while (!cfg_ready);
    field_sel = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver: offer the next word at the falling edge once the current one
  // was taken; hold the payload steady while the block stalls.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : byte_driver
    gap_byte_t nxt;
    if (!rst && (!in_valid || byte_taken)) begin
      if (sample_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = sample_bytes.pop_front();
        in_valid  <= 1'b1;
        char_byte <= nxt.char_byte;
        last_byte <= nxt.last_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side back-pressure: random stalls, or a forced long hold.
  always @(negedge clk) begin
    out_stall <= hold_results || ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge, predict on every accepted byte, then compare
  // every accepted result word against the oldest owed result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    allele_result_t predicted;
    allele_result_t want;
    if (rst) begin
      byte_taken = 1'b0;
    end else begin
      byte_taken = in_valid && !in_stall;
      if (byte_taken && take_byte(char_byte, last_byte, predicted))
        pending_alleles.push_back(predicted);
      if (out_valid && !out_stall) begin
        if (pending_alleles.size() == 0) begin
          report_mismatch("unexpected result word", first_allele, -1);
        end else begin
          want = pending_alleles.pop_front();
          if (first_allele !== want.allele_a)
            report_mismatch("first_allele", first_allele, want.allele_a);
          if (second_allele !== want.allele_b)
            report_mismatch("second_allele", second_allele, want.allele_b);
          if (missing_code !== want.miss)
            report_mismatch("missing_code", missing_code, want.miss);
        end
      end
    end
  end

  // Watchdog: end the run with a failure once the cycle limit is passed.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** genotype_allele_parser_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, a directed set under the reset field index, then phases
  // that each pick a field index and an idling mode and push random samples.
  // ---------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] field_plan[8];
    int phase_start;
    bit paused;
    field_plan = '{4'd15, 4'd2, 4'd0, 4'd7, 4'd1, 4'd15, 4'd4, 4'd0};

    clear_sample();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: dot allele then saturated negative, a one-byte sample,
    // signed allele ended by junk with no second allele, token at index 0
    // followed by another, the byte extremes, a sample of only separators,
    // and extra alleles past the second.
    queue_text("./-99999");
    queue_text("0");
    queue_text("+7x");
    queue_text("a:b");
    queue_text("\377\001/");
    queue_text(":::");
    queue_text("1/2|3");
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      set_field_index(field_plan[ph]);
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase

      // Hold the result side off for a long stretch while bytes keep coming,
      // so the block backs up and stalls its input.
      if (ph == 4) begin
        fork
          begin : long_result_hold
            int held;
            hold_results = 1'b1;
            for (held = 0; held < LONG_HOLD_CYCLES; held++) @(posedge clk);
            hold_results = 1'b0;
          end
        join_none
      end

      phase_start = bytes_queued;
      paused = 1'b0;
      while (bytes_queued - phase_start < PHASE_BYTES) begin
        queue_sample();
        // Pause the sender mid-phase until the block has fully drained.
        if (ph == 2 && !paused && bytes_queued - phase_start >= PHASE_BYTES / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0 && pending_alleles.size() == 0)
      $display("** genotype_allele_parser_core: PASSED **");
    else
      $display("** genotype_allele_parser_core: FAILED **");
    $finish;
  end

endmodule
